/* sv/pid_pkg.sv */
// Package: constants and types for the packed integer decoder.
package pid_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned ValueW = 64;
    localparam int unsigned CountW = 4;
    localparam int unsigned SizeW  = 6;

    // Header decode
    localparam logic [ByteW-1:0] HdrTagMask  = 8'hC0;
    localparam logic [ByteW-1:0] HdrEscape   = 8'h80;
    localparam logic [ByteW-1:0] HdrSizeMask = 8'h3F;

    // Valid payload sizes in bytes
    localparam logic [SizeW-1:0] SizeOne   = 6'd1;
    localparam logic [SizeW-1:0] SizeTwo   = 6'd2;
    localparam logic [SizeW-1:0] SizeFour  = 6'd4;
    localparam logic [SizeW-1:0] SizeEight = 6'd8;

    typedef logic [ValueW-1:0] value_t;
    typedef logic [CountW-1:0] count_t;

endpackage

/* sv/packed_integer_decoder.sv */
// Top level: streaming decoder for packed variable-length signed integers.
//
// The block takes one raw byte per item on the s_ channel and gives one
// 64-bit signed result per complete integer on the m_ channel. A header whose
// top two bits are not binary 10 is an immediate value, sign-extended from
// 8 bits. A header 10xxxxxx carries a size in its low six bits; sizes 1, 2
// and 4 (and 8 when allow_eight_byte is set) are followed by that many
// big-endian payload bytes whose value is sign-extended to 64 bits. Any other
// size yields a result with m_tuser (error) high and value zero, and the
// next byte is read as a header. Header and payload bytes give no result
// until the last payload byte arrives. Rate: one byte per clock cycle,
// sustained while the output register is free for each result; each byte
// is held in the input register, where the header decode and accumulator
// shift run, and its result is then registered in the output register.
// Bytes that give no result go on while a result waits for m_tready. The
// configuration register resets to 1 and is sampled only at header bytes.
module packed_integer_decoder
    import pid_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ByteW-1:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ValueW-1:0] m_tdata,   // [63:0] value
    output logic              m_tuser,   // [0] error
    // configuration write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data   // allow_eight_byte
);

    // Input register
    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;

    // Decoder state
    count_t bytes_left_reg, bytes_left_next;
    count_t payload_size_reg, payload_size_next;
    value_t acc_reg, acc_next;
    logic   allow_eight_reg;

    // Output register
    logic   out_valid_reg;
    value_t out_value_reg;
    logic   out_error_reg;

    // Per-byte decode results
    logic             res_valid;
    value_t           res_value;
    logic             res_error;
    logic             out_free;
    logic             advance;
    logic [SizeW-1:0] hdr_size;
    value_t           acc_shifted;

    assign cfg_ready = 1'b1;

    // The output register is free when empty or being emptied this cycle.
    assign out_free = !out_valid_reg || m_tready;
    // Process the held byte unless its result has nowhere to go.
    assign advance  = in_valid_reg && (!res_valid || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign hdr_size    = in_byte_reg[SizeW-1:0] & HdrSizeMask[SizeW-1:0];
    assign acc_shifted = {acc_reg[ValueW-ByteW-1:0], in_byte_reg};

    always_comb begin
        bytes_left_next   = bytes_left_reg;
        payload_size_next = payload_size_reg;
        acc_next          = acc_reg;
        res_valid         = 1'b0;
        res_value         = '0;
        res_error         = 1'b0;
        if (bytes_left_reg == '0) begin
            if ((in_byte_reg & HdrTagMask) != HdrEscape) begin
                // Immediate: the header is the value.
                res_valid = 1'b1;
                res_value = {{(ValueW-ByteW){in_byte_reg[ByteW-1]}}, in_byte_reg};
            end else if (hdr_size inside {SizeOne, SizeTwo, SizeFour} ||
                         (hdr_size == SizeEight && allow_eight_reg)) begin
                bytes_left_next   = count_t'(hdr_size);
                payload_size_next = count_t'(hdr_size);
                acc_next          = '0;
            end else begin
                // Bad size: flag it and consume no payload.
                res_valid = 1'b1;
                res_error = 1'b1;
            end
        end else begin
            acc_next        = acc_shifted;
            bytes_left_next = bytes_left_reg - count_t'(1);
            if (bytes_left_reg == count_t'(1)) begin
                res_valid = 1'b1;
                case (payload_size_reg)
                    count_t'(SizeOne):
                        res_value = {{(ValueW-8){acc_shifted[7]}}, acc_shifted[7:0]};
                    count_t'(SizeTwo):
                        res_value = {{(ValueW-16){acc_shifted[15]}}, acc_shifted[15:0]};
                    count_t'(SizeFour):
                        res_value = {{(ValueW-32){acc_shifted[31]}}, acc_shifted[31:0]};
                    default:
                        res_value = acc_shifted;
                endcase
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            bytes_left_reg   <= '0;
            payload_size_reg <= '0;
            acc_reg          <= '0;
            allow_eight_reg  <= 1'b1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                allow_eight_reg <= cfg_data;
            end
            // Load the input register, or drop it once processed.
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                bytes_left_reg   <= bytes_left_next;
                payload_size_reg <= payload_size_next;
                acc_reg          <= acc_next;
            end
            // Hold the result until taken.
            if (advance && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && res_valid) begin
            out_value_reg <= res_value;
            out_error_reg <= res_error;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_error_reg;

endmodule
